// ----- rtl/hsad_pkg.sv -----
// Package for the hall sensor angle decoder.
// Holds config field widths, register indexes, the config struct and the sector tables.
// No dependencies.
package hsad_pkg;

  // Config registers are 16-bit unsigned Q1.15
  localparam int unsigned CfgW          = 16;
  localparam int unsigned CfgFrac       = 15;
  localparam int unsigned LevelFracBits = 15;

  // Register indexes on the config port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_FILTER_GAIN    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FILTER_DECAY   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD_HIGH = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD_LOW  = 2'd3;

  // Reset values of the config registers
  localparam logic [CfgW-1:0] GAIN_RST     = 16'd32768;
  localparam logic [CfgW-1:0] DECAY_RST    = 16'd0;
  localparam logic [CfgW-1:0] THR_HIGH_RST = 16'd19661;
  localparam logic [CfgW-1:0] THR_LOW_RST  = 16'd13107;

  // Sector codes that carry no position
  localparam logic [2:0] CODE_ALL_LOW  = 3'd0;
  localparam logic [2:0] CODE_ALL_HIGH = 3'd7;

  typedef struct packed {
    logic [CfgW-1:0] gain;
    logic [CfgW-1:0] decay;
    logic [CfgW-1:0] thr_high;
    logic [CfgW-1:0] thr_low;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  pos;
    logic [15:0] angle;
    logic        valid;
  } sect_res_t;

  // Map a valid sector code to its sixth of a turn
  function automatic logic [2:0] hsad_sector_pos(input logic [2:0] code);
    logic [2:0] pos;
    case (code)
      3'd1:    pos = 3'd5;
      3'd2:    pos = 3'd3;
      3'd3:    pos = 3'd4;
      3'd4:    pos = 3'd1;
      3'd5:    pos = 3'd0;
      3'd6:    pos = 3'd2;
      default: pos = 3'd0;
    endcase
    return pos;
  endfunction

  // Angle of a sixth in Q3.13 radians, round(pos * 2pi / 6)
  function automatic logic [15:0] hsad_angle(input logic [2:0] pos);
    logic [15:0] ang;
    case (pos)
      3'd0:    ang = 16'd0;
      3'd1:    ang = 16'd8579;
      3'd2:    ang = 16'd17157;
      3'd3:    ang = 16'd25736;
      3'd4:    ang = 16'd34315;
      3'd5:    ang = 16'd42893;
      default: ang = 16'd0;
    endcase
    return ang;
  endfunction

endpackage

// ----- rtl/hsad_channel.sv -----
// One hall channel: first-order low-pass filter and hysteresis comparator.
// Depends on hsad_pkg.
module hsad_channel import hsad_pkg::*; #(
  parameter int unsigned LEVEL_FRAC_BITS = LevelFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic hall_i,
  input  cfg_t cfg_i,
  output logic bit_d_o
);

  localparam int unsigned LvlW = LEVEL_FRAC_BITS + 1;
  localparam int unsigned PrdW = CfgW + LvlW;
  localparam int unsigned SumW = PrdW + 1;
  localparam int unsigned ShW  = SumW - CfgFrac;
  localparam int unsigned CmpW = CfgW + LEVEL_FRAC_BITS + 1;
  localparam logic [LvlW-1:0] One = LvlW'(1) << LEVEL_FRAC_BITS;

  logic [LvlW-1:0] level_q, level_d;
  logic            bit_q, bit_d;
  logic [PrdW-1:0] decay_prod;
  logic [SumW-1:0] sum;
  logic [ShW-1:0]  sum_sh;
  logic [CmpW-1:0] lvl_scaled, thr_high_scaled, thr_low_scaled;

  // Filter: weighted input plus decayed level, truncate, saturate at one
  always_comb begin
    decay_prod = PrdW'(cfg_i.decay) * PrdW'(level_q);
    sum        = SumW'(decay_prod);
    if (hall_i) begin
      sum = sum + (SumW'(cfg_i.gain) << LEVEL_FRAC_BITS);
    end
    sum_sh = ShW'(sum >> CfgFrac);
    if (sum_sh > ShW'(One)) begin
      level_d = One;
    end else begin
      level_d = LvlW'(sum_sh);
    end
  end

  // Hysteresis: set test wins over clear test
  always_comb begin
    lvl_scaled      = CmpW'(level_d) << CfgFrac;
    thr_high_scaled = CmpW'(cfg_i.thr_high) << LEVEL_FRAC_BITS;
    thr_low_scaled  = CmpW'(cfg_i.thr_low) << LEVEL_FRAC_BITS;
    if (lvl_scaled >= thr_high_scaled) begin
      bit_d = 1'b1;
    end else if (lvl_scaled <= thr_low_scaled) begin
      bit_d = 1'b0;
    end else begin
      bit_d = bit_q;
    end
  end

  assign bit_d_o = bit_d;

  // Advance channel state once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      bit_q   <= 1'b0;
    end else if (en_i) begin
      level_q <= level_d;
      bit_q   <= bit_d;
    end
  end

endmodule

// ----- rtl/hsad_sector.sv -----
// Sector decode: qualified code to position and angle, holding the last valid position.
// Depends on hsad_pkg.
module hsad_sector import hsad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic [2:0] code_i,
  output sect_res_t res_o
);

  logic [2:0] last_pos_q, last_pos_d;
  logic       code_ok;

  // Codes with all bits equal carry no position
  assign code_ok    = (code_i != CODE_ALL_LOW) && (code_i != CODE_ALL_HIGH);
  assign last_pos_d = code_ok ? hsad_sector_pos(code_i) : last_pos_q;

  assign res_o.pos   = last_pos_d;
  assign res_o.angle = hsad_angle(last_pos_d);
  assign res_o.valid = code_ok;

  // Hold the last good position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= 3'd0;
    end else if (en_i) begin
      last_pos_q <= last_pos_d;
    end
  end

endmodule

// ----- rtl/hall_sensor_angle_decoder.sv -----
// Hall sensor angle decoder: top level with config registers, input and result registers.
// Depends on hsad_pkg, hsad_channel and hsad_sector.
//
// Takes one word of three raw hall bits per cycle while in_stall_o is low and returns
// one result word per input word. An accepted word is held first in the input register
// and then in the result register, which drives the outputs. Each
// line is low-pass filtered (level' = min(1, (gain*bit + decay*level) >> 15)), qualified by a
// hysteresis comparator, and the three bits form a sector code that maps to a position in
// sixths of a turn and a Q3.13 angle. Codes 0 and 7 clear angle_valid and repeat the last
// position. The rate of one word per cycle, when the output is not stalled, is set by the
// filter update, a single multiply-add per channel that closes its loop between the input
// register and the result register. Write config only while no word is in flight.
module hall_sensor_angle_decoder import hsad_pkg::*; #(
  parameter int unsigned LEVEL_FRAC_BITS = LevelFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               hall_a_i,
  input  logic               hall_b_i,
  input  logic               hall_c_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         position_sixth_o,
  output logic [15:0]        angle_rad_o,
  output logic [2:0]         sector_code_o,
  output logic               angle_valid_o
);

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [2:0] s1_hall_q;
  logic       out_valid_q;
  logic       out_free;
  logic       s1_adv;
  logic       in_acc;
  logic [2:0] bit_d;
  sect_res_t  sect_res;
  logic [2:0] res_pos_q;
  logic [15:0] res_angle_q;
  logic [2:0] res_code_q;
  logic       res_valid_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain     <= GAIN_RST;
      cfg_q.decay    <= DECAY_RST;
      cfg_q.thr_high <= THR_HIGH_RST;
      cfg_q.thr_low  <= THR_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FILTER_GAIN:    cfg_q.gain     <= cfg_data_i;
        REG_FILTER_DECAY:   cfg_q.decay    <= cfg_data_i;
        REG_THRESHOLD_HIGH: cfg_q.thr_high <= cfg_data_i;
        REG_THRESHOLD_LOW:  cfg_q.thr_low  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: result register frees when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_hall_q <= {hall_a_i, hall_b_i, hall_c_i};
    end
  end

  // Filter and qualify each line
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    hsad_channel #(
      .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_channel (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (s1_adv),
      .hall_i  (s1_hall_q[ch]),
      .cfg_i   (cfg_q),
      .bit_d_o (bit_d[ch])
    );
  end

  // Decode the sector code
  hsad_sector u_sector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .code_i (bit_d),
    .res_o  (sect_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_pos_q   <= sect_res.pos;
      res_angle_q <= sect_res.angle;
      res_code_q  <= bit_d;
      res_valid_q <= sect_res.valid;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_sixth_o = res_pos_q;
  assign angle_rad_o      = res_angle_q;
  assign sector_code_o    = res_code_q;
  assign angle_valid_o    = res_valid_q;

  // Valid flag agrees with the code it was decoded from
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_valid_q == ((res_code_q != CODE_ALL_LOW) &&
                                     (res_code_q != CODE_ALL_HIGH))))
    else $error("angle_valid does not match sector_code");

  // Angle follows the reported position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_angle_q == hsad_angle(res_pos_q)))
    else $error("angle_rad does not match position_sixth");

  // A word leaving the input register lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("word lost between input and result register");

  // Input stalls only while a word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room to advance");

endmodule
